### rtl/core/asn_text_parser_macros.svh
// Assertion macros used by the AS number text parser top level.
`ifndef ASN_TEXT_PARSER_MACROS_SVH
`define ASN_TEXT_PARSER_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define ATP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ATP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/atp_pkg.sv
// Types and constants of the AS number text parser.
package atp_pkg;

    // String length limit and width of character positions
    localparam int unsigned MAX_CHARS = 64;
    localparam int unsigned POS_W     = 7;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_CHARS);

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAX_ZERO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CALL_VARIANT = 2'd1;

    // Call variants; the unused code behaves as convert
    localparam logic [1:0] CV_CONVERT = 2'd0;
    localparam logic [1:0] CV_PARSE   = 2'd1;
    localparam logic [1:0] CV_MATCH   = 2'd2;

    // Characters
    localparam logic [7:0] CH_END  = 8'h00;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [2:0] {
        PH_START,
        PH_HIGH,
        PH_LOW_FIRST,
        PH_LOW,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        NOTA_PLAIN,
        NOTA_DOT,
        NOTA_DOT_PLUS
    } t_nota;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PARTIAL,
        KIND_EXACT
    } t_kind;

    typedef struct packed {
        logic  accepted;
        logic  partial;
        t_nota nota;
    } t_outcome;

    typedef struct packed {
        t_phase           phase;
        logic [31:0]      high_part;
        logic [15:0]      low_part;
        logic             field_zero;
        logic [POS_W-1:0] char_index;
        logic [POS_W-1:0] stop_index;
        t_outcome         outcome;
    } t_state;

    typedef struct packed {
        logic       relax_zero;
        logic [1:0] call_variant;
    } t_cfg;

    typedef struct packed {
        logic             accepted;
        logic [31:0]      asn_value;
        t_nota            notation;
        logic             partial_match;
        t_kind            match_kind;
        logic [POS_W-1:0] stop_position;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:      PH_START,
        high_part:  32'd0,
        low_part:   16'd0,
        field_zero: 1'b0,
        char_index: {POS_W{1'b0}},
        stop_index: {POS_W{1'b0}},
        outcome:    '{accepted: 1'b0, partial: 1'b0, nota: NOTA_PLAIN}
    };

    localparam t_cfg CFG_RESET = '{relax_zero: 1'b0, call_variant: CV_CONVERT};

endpackage

### rtl/core/atp_char_if.sv
// Character input channel of the AS number text parser.
interface atp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

### rtl/core/atp_cfg_if.sv
// Configuration write channel of the AS number text parser.
interface atp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [atp_pkg::CFG_IDX_W-1:0]  index;
    logic [atp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/atp_res_if.sv
// Result channel of the AS number text parser.
interface atp_res_if;
    logic                       valid;
    logic                       ready;
    logic                       accepted;
    logic [31:0]                asn_value;
    logic [1:0]                 notation;
    logic                       partial_match;
    logic [1:0]                 match_kind;
    logic [atp_pkg::POS_W-1:0] stop_position;

    modport source (output valid, output accepted, output asn_value, output notation,
                    output partial_match, output match_kind, output stop_position,
                    input ready);
    modport sink   (input valid, input accepted, input asn_value, input notation,
                    input partial_match, input match_kind, input stop_position,
                    output ready);
endinterface

### rtl/core/atp_cfg_regs.sv
// Configuration registers of the AS number text parser.
module atp_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    atp_cfg_if.sink       i_cfg,
    output atp_pkg::t_cfg o_cfg
);
    import atp_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken
    assign i_cfg.ready = 1'b1;

    // Decode the register index
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_RELAX_ZERO:   n_cfg.relax_zero   = i_cfg.data[0];
                CFG_CALL_VARIANT: n_cfg.call_variant = i_cfg.data[1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

### rtl/core/atp_step.sv
// Next-state and result logic for one character of the AS number text parser.
module atp_step (
    input  atp_pkg::t_state  i_state,
    input  logic [7:0]       i_ch,
    input  atp_pkg::t_cfg    i_cfg,
    output atp_pkg::t_state  o_state,
    output atp_pkg::t_result o_result,
    output logic             o_end
);
    import atp_pkg::*;

    // Record a final decision and ignore the rest of the string
    function automatic t_state f_settle(t_state s, logic acc, logic part, t_nota nota,
                                        logic [POS_W-1:0] stop);
        t_state r;
        r                  = s;
        r.phase            = PH_DONE;
        r.outcome.accepted = acc;
        r.outcome.partial  = part;
        r.outcome.nota     = nota;
        r.stop_index       = stop;
        return r;
    endfunction

    logic             is_digit;
    logic [3:0]       digit;
    logic [35:0]      high_x10;
    logic [19:0]      low_x10;
    logic [POS_W-1:0] pos;
    logic             is_end;
    t_state           dotted;
    t_state           s;

    always_comb begin
        pos      = i_state.char_index;
        is_end   = (i_ch == CH_END);
        is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        digit    = is_digit ? 4'(i_ch - CH_ZERO) : 4'd0;

        // Multiply by ten as shift-and-add, then add the digit
        high_x10 = ({4'b0, i_state.high_part} << 3) + ({4'b0, i_state.high_part} << 1)
                 + 36'(digit);
        low_x10  = ({4'b0, i_state.low_part} << 3) + ({4'b0, i_state.low_part} << 1)
                 + 20'(digit);

        // Close a dotted number
        if (i_cfg.call_variant != CV_PARSE && !is_end) begin
            dotted = f_settle(i_state, 1'b0, 1'b0, NOTA_PLAIN, pos);
        end else if (i_state.high_part[31:16] != 16'd0) begin
            dotted = f_settle(i_state, 1'b0, 1'b0, NOTA_PLAIN, pos);
        end else if (!i_cfg.relax_zero && i_state.high_part == 32'd0
                     && i_state.low_part == 16'd0) begin
            dotted = f_settle(i_state, 1'b0, i_cfg.call_variant == CV_MATCH,
                              NOTA_PLAIN, pos);
        end else begin
            dotted = f_settle(i_state, 1'b1, 1'b0,
                              (i_state.high_part == 32'd0) ? NOTA_DOT_PLUS : NOTA_DOT, pos);
        end

        // Advance the phase
        s = i_state;
        case (i_state.phase)
            PH_START: begin
                if (!is_digit) begin
                    s = f_settle(i_state, 1'b0, 1'b0, NOTA_PLAIN, pos);
                end else begin
                    s.high_part  = {28'd0, digit};
                    s.field_zero = (digit == 4'd0);
                    s.stop_index = pos;
                    s.phase      = PH_HIGH;
                end
            end
            PH_HIGH: begin
                if (is_digit) begin
                    if (i_state.field_zero) begin
                        s = f_settle(i_state, 1'b0, 1'b0, NOTA_PLAIN, i_state.stop_index);
                    end else if (high_x10[35:32] != 4'd0) begin
                        s = f_settle(i_state, 1'b0, 1'b0, NOTA_PLAIN, pos);
                    end else begin
                        s.high_part = high_x10[31:0];
                    end
                end else if (i_ch == CH_DOT) begin
                    s.low_part   = 16'd0;
                    s.field_zero = 1'b0;
                    s.phase      = PH_LOW_FIRST;
                end else begin
                    // Trailing text or end mark closes a plain number
                    s = f_settle(i_state,
                                 !(!i_cfg.relax_zero && i_state.high_part == 32'd0),
                                 1'b0, NOTA_PLAIN, pos);
                end
            end
            PH_LOW_FIRST: begin
                if (is_end && i_cfg.call_variant == CV_MATCH) begin
                    s = f_settle(i_state, 1'b0, 1'b1, NOTA_PLAIN, pos);
                end else if (is_digit) begin
                    s.low_part   = {12'd0, digit};
                    s.field_zero = (digit == 4'd0);
                    s.stop_index = pos;
                    s.phase      = PH_LOW;
                end else begin
                    s = dotted;
                end
            end
            PH_LOW: begin
                if (is_digit) begin
                    if (i_state.field_zero) begin
                        s = f_settle(i_state, 1'b0, 1'b0, NOTA_PLAIN, i_state.stop_index);
                    end else if (low_x10[19:16] != 4'd0) begin
                        s = f_settle(i_state, 1'b0, 1'b0, NOTA_PLAIN, pos);
                    end else begin
                        s.low_part = low_x10[15:0];
                    end
                end else begin
                    s = dotted;
                end
            end
            PH_DONE: s = i_state;
            default: s = i_state;
        endcase

        // Count characters, saturating at the limit
        if (!is_end && i_state.char_index < MAX_POS) begin
            s.char_index = i_state.char_index + 1'b1;
        end

        // Build the result for an end mark
        o_result.accepted      = s.outcome.accepted;
        o_result.notation      = s.outcome.nota;
        o_result.partial_match = s.outcome.partial;
        if (!s.outcome.accepted) begin
            o_result.asn_value = 32'd0;
        end else if (s.outcome.nota == NOTA_PLAIN) begin
            o_result.asn_value = s.high_part;
        end else begin
            o_result.asn_value = {s.high_part[15:0], s.low_part};
        end
        if (i_cfg.call_variant != CV_MATCH) begin
            o_result.match_kind = KIND_NONE;
        end else if (s.outcome.accepted && !s.outcome.partial) begin
            o_result.match_kind = KIND_EXACT;
        end else if (s.outcome.partial) begin
            o_result.match_kind = KIND_PARTIAL;
        end else begin
            o_result.match_kind = KIND_NONE;
        end
        o_result.stop_position = (s.stop_index > MAX_POS) ? MAX_POS : s.stop_index;

        o_state = s;
        o_end   = is_end;
    end
endmodule

### rtl/core/asn_text_parser.sv
// AS number text parser top level: input register, one-character step, result register.
// Throughput: one character per cycle while no end mark waits on a full result register;
// input register and result register are decoupled. An end-mark transaction loads the
// input register, then its result loads the result register once that register is free;
// a stalled result only stalls an end mark behind it.
// Reset: configuration to zero, parser to start of string, both registers empty.
`include "asn_text_parser_macros.svh"

module asn_text_parser (
    input  logic     i_clk,
    input  logic     i_rst_n,
    atp_char_if.sink i_char,
    atp_cfg_if.sink  i_cfg,
    atp_res_if.source o_res
);
    import atp_pkg::*;

    t_cfg       cfg;
    logic       r_in_valid;
    logic       n_in_valid;
    logic [7:0] r_ch;
    t_state     r_state;
    t_state     n_state;
    t_state     step_state;
    t_result    step_res;
    logic       step_end;
    t_result    r_res;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;
    logic       consume;
    logic       consume_end;

    atp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    atp_step u_step (
        .i_state  (r_state),
        .i_ch     (r_ch),
        .i_cfg    (cfg),
        .o_state  (step_state),
        .o_result (step_res),
        .o_end    (step_end)
    );

    // Process the held character unless it is an end mark facing a full result register that is not being taken
    assign out_free     = !r_out_valid || o_res.ready;
    assign consume      = r_in_valid && (!step_end || out_free);
    assign consume_end  = consume && step_end;
    assign i_char.ready = !r_in_valid || consume;

    // Next values of control state
    always_comb begin
        n_in_valid = r_in_valid;
        if (consume) begin
            n_in_valid = 1'b0;
        end
        if (i_char.valid && i_char.ready) begin
            n_in_valid = 1'b1;
        end

        n_state = r_state;
        if (consume) begin
            n_state = step_end ? STATE_RESET : step_state;
        end

        n_out_valid = r_out_valid;
        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (consume_end) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold payloads
    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_ch <= i_char.ch;
        end
        if (consume_end) begin
            r_res <= step_res;
        end
    end

    // Drive the result transaction
    assign o_res.valid         = r_out_valid;
    assign o_res.accepted      = r_res.accepted;
    assign o_res.asn_value     = r_res.asn_value;
    assign o_res.notation      = r_res.notation;
    assign o_res.partial_match = r_res.partial_match;
    assign o_res.match_kind    = r_res.match_kind;
    assign o_res.stop_position = r_res.stop_position;

    `ATP_ASSERT_NEXT(a_end_loads_result, i_clk, i_rst_n,
        r_in_valid && (r_ch == CH_END) && !r_out_valid, r_out_valid,
        "end mark did not load the result register")
    `ATP_ASSERT_NEXT(a_end_clears_state, i_clk, i_rst_n, consume_end,
        (r_state.phase == PH_START) && (r_state.char_index == '0),
        "parser state not cleared after an end mark")
    `ATP_ASSERT_NOW(a_stall_needs_item, i_clk, i_rst_n, !i_char.ready,
        r_in_valid && (r_ch == CH_END) && r_out_valid,
        "input stalled without a blocked end mark")
endmodule
